[rtl/arpc_pkg.sv]
package arpc_pkg;

  localparam int TABLE_ENTRIES_DEF = 8;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 8'd1;

  localparam logic [15:0] OP_REQUEST      = 16'd1;
  localparam logic [15:0] ARP_MIN_PAYLOAD = 16'd28;

  typedef enum logic [1:0] {
    FUNC_RX         = 2'd0,
    FUNC_LOOKUP_IP  = 2'd1,
    FUNC_LOOKUP_MAC = 2'd2,
    FUNC_ANNOUNCE   = 2'd3
  } func_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
  } entry_t;

  // Write request from the control FSM into the table
  typedef struct packed {
    logic   en;
    entry_t ent;
  } tbl_wr_t;

endpackage

[rtl/arpc_if.sv]
interface arpc_in_if;
  import arpc_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] payload_length;
  logic [15:0] arp_operation;
  logic [47:0] src_mac;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;
  logic [31:0] query_ip;
  logic [47:0] query_mac;

  modport source (output valid, func, payload_length, arp_operation, src_mac,
                  src_ip, dst_ip, query_ip, query_mac, input ready);
  modport sink   (input valid, func, payload_length, arp_operation, src_mac,
                  src_ip, dst_ip, query_ip, query_mac, output ready);
  modport mon    (input valid, ready, func, payload_length, arp_operation, src_mac,
                  src_ip, dst_ip, query_ip, query_mac);
endinterface

interface arpc_out_if;
  logic        valid;
  logic        ready;
  logic        reply_valid;
  logic [47:0] reply_target_mac;
  logic [31:0] reply_target_ip;
  logic        found;
  logic [31:0] found_ip;
  logic [47:0] found_mac;

  modport source (output valid, reply_valid, reply_target_mac, reply_target_ip,
                  found, found_ip, found_mac, input ready);
  modport sink   (input valid, reply_valid, reply_target_mac, reply_target_ip,
                  found, found_ip, found_mac, output ready);
  modport mon    (input valid, ready, reply_valid, reply_target_mac, reply_target_ip,
                  found, found_ip, found_mac);
endinterface

interface arpc_cfg_if;
  import arpc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
  modport mon    (input valid, ready, idx, data);
endinterface

[rtl/arpc_table.sv]
module arpc_table import arpc_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int IW            = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [IW-1:0] rd_idx,
  output entry_t        rd_ent,
  input  logic [IW-1:0] wr_idx,
  input  tbl_wr_t       wr
);

  entry_t                   mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] vld_r;
  entry_t                   rdata_r;
  logic                     rvld_r;

  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_idx];
    if (wr.en) begin
      mem[wr_idx] <= wr.ent;
    end
  end

  // An entry never written reads as the cleared value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      rvld_r <= vld_r[rd_idx];
      if (wr.en) begin
        vld_r[wr_idx] <= 1'b1;
      end
    end
  end

  assign rd_ent = rvld_r ? rdata_r : '0;

endmodule

[rtl/arp_cache_responder_core.sv]
// Channel  Dir  Handshake      Contents
// cfg_if   in   valid/ready    idx 0 own_ip, idx 1 own_mac, data 48 bits
// in_if    in   valid/ready    func, packet fields, lookup keys
// out_if   out  valid/ready    reply and lookup result, one per item
//
// One item at a time. Announce and short packets skip the scan (accept, result);
// learn and lookup walk the table one entry per cycle through the registered
// read port of the table memory.
// Reset clears the table valid bits, own_ip and own_mac.
// A result waiting on out_if holds the next item's completion, not its acceptance.
module arp_cache_responder_core import arpc_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input logic       clk,
  input logic       rst_n,
  arpc_cfg_if.sink  cfg_if,
  arpc_in_if.sink   in_if,
  arpc_out_if.source out_if
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] NUM_ENT = CW'(TABLE_ENTRIES);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

  state_t        state_r;
  func_t         func_r;
  logic          learn_r;
  logic          rep_r;
  logic [47:0]   smac_r;
  logic [31:0]   sip_r;
  logic [31:0]   qip_r;
  logic [47:0]   qmac_r;
  logic [CW-1:0] cnt_r;
  logic          pend_r;
  logic [IW-1:0] pidx_r;
  logic          hit_r;
  logic [IW-1:0] hidx_r;
  entry_t        hent_r;

  logic [31:0]   own_ip_r;
  logic [47:0]   own_mac_r;

  logic          out_valid_r;
  logic          out_reply_r;
  logic [47:0]   out_tmac_r;
  logic [31:0]   out_tip_r;
  logic          out_found_r;
  logic [31:0]   out_fip_r;
  logic [47:0]   out_fmac_r;

  logic          in_xfer;
  logic          in_long;
  logic          out_free;
  logic [IW-1:0] rd_idx;
  entry_t        rd_ent;
  logic          match;
  tbl_wr_t       tbl_wr;
  logic [IW-1:0] wr_idx;
  func_t         in_func;

  assign in_func  = func_t'(in_if.func);
  assign in_xfer  = in_if.valid && in_if.ready;
  assign in_long  = in_if.payload_length >= ARP_MIN_PAYLOAD;
  assign out_free = !out_valid_r || out_if.ready;

  assign in_if.ready  = (state_r == ST_IDLE);
  assign cfg_if.ready = 1'b1;

  assign rd_idx = (cnt_r < NUM_ENT) ? cnt_r[IW-1:0] : '0;

  always_comb begin
    if (learn_r) begin
      match = (rd_ent.ip == '0);
    end else if (func_r == FUNC_LOOKUP_IP) begin
      match = (rd_ent.ip == qip_r);
    end else begin
      match = (rd_ent.mac == qmac_r);
    end
  end

  // Learn into the first empty slot, else slot 0
  assign tbl_wr.en      = (state_r == ST_DONE) && out_free && learn_r;
  assign tbl_wr.ent.ip  = sip_r;
  assign tbl_wr.ent.mac = smac_r;
  assign wr_idx         = hit_r ? hidx_r : '0;

  arpc_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IW            (IW)
  ) u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_idx (rd_idx),
    .rd_ent (rd_ent),
    .wr_idx (wr_idx),
    .wr     (tbl_wr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r  <= '0;
      own_mac_r <= '0;
    end else if (cfg_if.valid) begin
      if (cfg_if.idx == CFG_OWN_IP) begin
        own_ip_r <= cfg_if.data[31:0];
      end else if (cfg_if.idx == CFG_OWN_MAC) begin
        own_mac_r <= cfg_if.data[47:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      hit_r       <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            func_r  <= in_func;
            smac_r  <= in_if.src_mac;
            sip_r   <= in_if.src_ip;
            qip_r   <= in_if.query_ip;
            qmac_r  <= in_if.query_mac;
            learn_r <= (in_func == FUNC_RX) && in_long;
            rep_r   <= (in_func == FUNC_RX) && in_long &&
                       (in_if.arp_operation == OP_REQUEST) &&
                       (in_if.dst_ip == own_ip_r);
            hit_r   <= 1'b0;
            cnt_r   <= '0;
            pend_r  <= 1'b0;
            if ((in_func == FUNC_LOOKUP_IP) || (in_func == FUNC_LOOKUP_MAC) ||
                ((in_func == FUNC_RX) && in_long)) begin
              state_r <= ST_SCAN;
            end else begin
              state_r <= ST_DONE;
            end
          end
        end
        ST_SCAN: begin
          // Issue the next read while checking the previous one
          if (cnt_r < NUM_ENT) begin
            cnt_r  <= cnt_r + 1'b1;
            pidx_r <= cnt_r[IW-1:0];
            pend_r <= 1'b1;
          end else begin
            pend_r <= 1'b0;
          end
          if (pend_r && match) begin
            hit_r   <= 1'b1;
            hidx_r  <= pidx_r;
            hent_r  <= rd_ent;
            state_r <= ST_DONE;
          end else if (pend_r && (cnt_r == NUM_ENT)) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_reply_r <= rep_r || (func_r == FUNC_ANNOUNCE);
            out_tmac_r  <= (func_r == FUNC_ANNOUNCE) ? '1 : (rep_r ? smac_r : '0);
            out_tip_r   <= (func_r == FUNC_ANNOUNCE) ? '1 : (rep_r ? sip_r : '0);
            out_found_r <= hit_r && ((func_r == FUNC_LOOKUP_IP) ||
                                     (func_r == FUNC_LOOKUP_MAC));
            out_fmac_r  <= (hit_r && (func_r == FUNC_LOOKUP_IP)) ? hent_r.mac : '0;
            out_fip_r   <= (hit_r && (func_r == FUNC_LOOKUP_MAC)) ? hent_r.ip : '0;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.reply_valid      = out_reply_r;
  assign out_if.reply_target_mac = out_tmac_r;
  assign out_if.reply_target_ip  = out_tip_r;
  assign out_if.found            = out_found_r;
  assign out_if.found_ip         = out_fip_r;
  assign out_if.found_mac        = out_fmac_r;

  // own_mac is stored but drives no output of the block
  logic own_mac_unused;
  assign own_mac_unused = ^own_mac_r;

endmodule

[rtl/arpc_checker.sv]
module arpc_checker (
  input logic        clk,
  input logic        rst_n,
  arpc_in_if.sink    in_if,
  arpc_out_if.source out_if
);

  // A waiting result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.ready |=> out_if.valid &&
      $stable(out_if.reply_valid) && $stable(out_if.reply_target_mac) &&
      $stable(out_if.reply_target_ip) && $stable(out_if.found) &&
      $stable(out_if.found_ip) && $stable(out_if.found_mac))
    else $error("result changed while stalled");

  // One item in flight: no new item right after a transfer in
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> !in_if.ready)
    else $error("input taken while an item is in flight");

  a_reply_xor_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> !(out_if.reply_valid && out_if.found))
    else $error("reply and lookup hit in one result");

  a_found_one_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && (out_if.found_mac != 48'd0) |-> out_if.found && (out_if.found_ip == 32'd0))
    else $error("lookup result fields inconsistent");

  a_no_reply_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.reply_valid |->
      (out_if.reply_target_mac == 48'd0) && (out_if.reply_target_ip == 32'd0))
    else $error("reply fields set without a reply");

endmodule

bind arp_cache_responder_core arpc_checker u_arpc_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_if  (in_if),
  .out_if (out_if)
);
